/* sv/swbt_pkg.sv */
// Shared constants, register codes, types and the Q1.16 product for the splat weight brush.
package swbt_pkg;

  localparam int W_W    = 16;
  localparam int FLOW_W = 17;
  localparam int EXP_W  = 20;
  localparam int N_INT  = 9;
  localparam int NL_MAX = 4;
  localparam int LAYERS_DEF = 4;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [2:0] {
    REG_RADIUS,
    REG_GAIN,
    REG_CURVE,
    REG_SHAPE,
    REG_FALLOFF,
    REG_BLEND,
    REG_TARGET,
    REG_NORM
  } cfg_reg_t;

  localparam logic [1:0] SHAPE_SQUARE  = 2'd1;
  localparam logic [1:0] SHAPE_DIAMOND = 2'd2;

  localparam logic [2:0] FALL_SMOOTH = 3'd1;
  localparam logic [2:0] FALL_SHARP  = 3'd2;
  localparam logic [2:0] FALL_CONST  = 3'd3;

  localparam logic [2:0] BL_ADD  = 3'd1;
  localparam logic [2:0] BL_SUB  = 3'd2;
  localparam logic [2:0] BL_MUL  = 3'd3;
  localparam logic [2:0] BL_OVER = 3'd4;
  localparam logic [2:0] BL_SOFT = 3'd5;
  localparam logic [2:0] BL_HARD = 3'd6;

  typedef struct packed {
    logic [NL_MAX-1:0][W_W-1:0] w;
    logic [FLOW_W-1:0]          flow;
  } texel_t;

  function automatic logic [16:0] qmul(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = a * b;
    return p[32:16];
  endfunction

endpackage

/* sv/swbt_sqrt.sv */
// Pipelined floor square root, one root bit per stage, with a carried side word.
module swbt_sqrt #(
  parameter int IN_W = 64,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_x,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [IN_W/2-1:0] out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int RW = IN_W / 2;
  localparam int MW = RW + 2;

  logic [RW-1:0]   v_r;
  logic [IN_W-1:0] x_r    [RW];
  logic [MW-1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SB_W-1:0] sb_r   [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic            p_v;
    logic [IN_W-1:0] p_x;
    logic [MW-1:0]   p_rem;
    logic [RW-1:0]   p_root;
    logic [SB_W-1:0] p_sb;
    logic [MW-1:0]   t;
    logic [MW-1:0]   trial;

    if (g == 0) begin : g_first
      assign p_v    = in_valid;
      assign p_x    = in_x;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_sb   = in_sb;
    end else begin : g_next
      assign p_v    = v_r[g-1];
      assign p_x    = x_r[g-1];
      assign p_rem  = rem_r[g-1];
      assign p_root = root_r[g-1];
      assign p_sb   = sb_r[g-1];
    end

    assign t     = {p_rem[MW-3:0], p_x[IN_W-1 -: 2]};
    assign trial = {p_root, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g]  <= p_x << 2;
        sb_r[g] <= p_sb;
        if (t >= trial) begin
          rem_r[g]  <= t - trial;
          root_r[g] <= {p_root[RW-2:0], 1'b1};
        end else begin
          rem_r[g]  <= t;
          root_r[g] <= {p_root[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_sb    = sb_r[RW-1];

endmodule

/* sv/swbt_div.sv */
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
module swbt_div #(
  parameter int LANES = 1,
  parameter int N_W   = 32,
  parameter int D_W   = 15,
  parameter int Q_W   = 16,
  parameter int SB_W  = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][N_W-1:0]   in_num,
  input  logic [D_W-1:0]              in_den,
  input  logic [SB_W-1:0]             in_sb,
  output logic                        out_valid,
  output logic [LANES-1:0][Q_W-1:0]   out_quo,
  output logic [SB_W-1:0]             out_sb
);

  localparam int RW = D_W + 1;

  logic [Q_W-1:0]                v_r;
  logic [D_W-1:0]                den_r [Q_W];
  logic [LANES-1:0][RW-1:0]      rem_r [Q_W];
  logic [LANES-1:0][Q_W-1:0]     low_r [Q_W];
  logic [LANES-1:0][Q_W-1:0]     quo_r [Q_W];
  logic [SB_W-1:0]               sb_r  [Q_W];

  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    logic                      p_v;
    logic [D_W-1:0]            p_den;
    logic [LANES-1:0][RW-1:0]  p_rem;
    logic [LANES-1:0][Q_W-1:0] p_low;
    logic [LANES-1:0][Q_W-1:0] p_quo;
    logic [SB_W-1:0]           p_sb;
    logic [LANES-1:0][RW:0]    t;
    logic [LANES-1:0]          ge;

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          p_rem[l] = RW'(in_num[l] >> Q_W);
          p_low[l] = in_num[l][Q_W-1:0];
        end
      end
      assign p_v   = in_valid;
      assign p_den = in_den;
      assign p_quo = '0;
      assign p_sb  = in_sb;
    end else begin : g_next
      assign p_v   = v_r[g-1];
      assign p_den = den_r[g-1];
      assign p_rem = rem_r[g-1];
      assign p_low = low_r[g-1];
      assign p_quo = quo_r[g-1];
      assign p_sb  = sb_r[g-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]  = {p_rem[l], p_low[l][Q_W-1]};
        ge[l] = t[l] >= {2'b00, p_den};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[g] <= p_den;
        sb_r[g]  <= p_sb;
        for (int l = 0; l < LANES; l++) begin
          rem_r[g][l] <= ge[l] ? RW'(t[l] - {2'b00, p_den}) : RW'(t[l]);
          low_r[g][l] <= p_low[l] << 1;
          quo_r[g][l] <= {p_quo[l][Q_W-2:0], ge[l]};
        end
      end
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_sb    = sb_r[Q_W-1];

endmodule

/* sv/swbt_pow.sv */
// Pipelined Q1.16 power: integer products, then sixteen nested roots each with a product.
module swbt_pow #(
  parameter int SB_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [16:0]                in_base,
  input  logic [swbt_pkg::EXP_W-1:0] in_expo,
  input  logic [SB_W-1:0]            in_sb,
  output logic                       out_valid,
  output logic [16:0]                out_pow,
  output logic [SB_W-1:0]            out_sb
);

  import swbt_pkg::*;

  localparam int PW = 17 + 16 + SB_W;

  logic [N_INT-1:0] iv_r;
  logic [16:0]      iacc_r  [N_INT];
  logic [16:0]      ibase_r [N_INT];
  logic [EXP_W-1:0] iexp_r  [N_INT];
  logic [SB_W-1:0]  isb_r   [N_INT];

  for (genvar j = 0; j < N_INT; j++) begin : g_int
    logic             p_v;
    logic [16:0]      p_acc;
    logic [16:0]      p_base;
    logic [EXP_W-1:0] p_exp;
    logic [SB_W-1:0]  p_sb;

    if (j == 0) begin : g_first
      assign p_v    = in_valid;
      assign p_acc  = ONE_Q16;
      assign p_base = in_base;
      assign p_exp  = in_expo;
      assign p_sb   = in_sb;
    end else begin : g_next
      assign p_v    = iv_r[j-1];
      assign p_acc  = iacc_r[j-1];
      assign p_base = ibase_r[j-1];
      assign p_exp  = iexp_r[j-1];
      assign p_sb   = isb_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        iv_r[j] <= 1'b0;
      end else if (en) begin
        iv_r[j] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        iacc_r[j]  <= (p_exp[EXP_W-1:16] > (EXP_W-16)'(j)) ? qmul(p_acc, p_base) : p_acc;
        ibase_r[j] <= p_base;
        iexp_r[j]  <= p_exp;
        isb_r[j]   <= p_sb;
      end
    end
  end

  logic [15:0]     fv_r;
  logic [16:0]     facc_r  [16];
  logic [16:0]     fs_r    [16];
  logic [15:0]     ffrac_r [16];
  logic [SB_W-1:0] fsb_r   [16];

  for (genvar k = 0; k < 16; k++) begin : g_frac
    logic            p_v;
    logic [16:0]     p_acc;
    logic [16:0]     p_s;
    logic [15:0]     p_frac;
    logic [SB_W-1:0] p_sb;
    logic            q_v;
    logic [16:0]     q_root;
    logic [PW-1:0]   q_pk;
    logic [16:0]     q_acc;
    logic [15:0]     q_frac;

    if (k == 0) begin : g_first
      assign p_v    = iv_r[N_INT-1];
      assign p_acc  = iacc_r[N_INT-1];
      assign p_s    = ibase_r[N_INT-1];
      assign p_frac = iexp_r[N_INT-1][15:0];
      assign p_sb   = isb_r[N_INT-1];
    end else begin : g_next
      assign p_v    = fv_r[k-1];
      assign p_acc  = facc_r[k-1];
      assign p_s    = fs_r[k-1];
      assign p_frac = ffrac_r[k-1];
      assign p_sb   = fsb_r[k-1];
    end

    swbt_sqrt #(.IN_W(34), .SB_W(PW)) u_root (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (p_v),
      .in_x     ({1'b0, p_s, 16'd0}),
      .in_sb    ({p_acc, p_frac, p_sb}),
      .out_valid(q_v),
      .out_root (q_root),
      .out_sb   (q_pk)
    );

    assign q_acc  = q_pk[PW-1 -: 17];
    assign q_frac = q_pk[PW-18 -: 16];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fv_r[k] <= 1'b0;
      end else if (en) begin
        fv_r[k] <= q_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        facc_r[k]  <= q_frac[15-k] ? qmul(q_acc, q_root) : q_acc;
        fs_r[k]    <= q_root;
        ffrac_r[k] <= q_frac;
        fsb_r[k]   <= q_pk[SB_W-1:0];
      end
    end
  end

  assign out_valid = fv_r[15];
  assign out_pow   = facc_r[15];
  assign out_sb    = fsb_r[15];

endmodule

/* sv/splat_weight_brush_texel.sv */
// Top level of the splat weight brush: configuration registers and the texel pipeline.
// One texel word enters per clock unless the pipeline holds; the depth is set mostly by the
// power stage, whose sixteen nested 17-bit roots take one bit per stage. The whole pipeline
// holds while a result word waits on out_ready, so nothing is lost. The user must write
// configuration only while no texel is in flight; the block itself does not enforce this.
module splat_weight_brush_texel #(
  parameter int LAYERS = swbt_pkg::LAYERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_offset_x,
  input  logic signed [15:0]          in_offset_z,
  input  logic [swbt_pkg::FLOW_W-1:0] in_flow,
  input  logic [swbt_pkg::W_W-1:0]    in_weight_in_0,
  input  logic [swbt_pkg::W_W-1:0]    in_weight_in_1,
  input  logic [swbt_pkg::W_W-1:0]    in_weight_in_2,
  input  logic [swbt_pkg::W_W-1:0]    in_weight_in_3,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swbt_pkg::W_W-1:0]    out_weight_out_0,
  output logic [swbt_pkg::W_W-1:0]    out_weight_out_1,
  output logic [swbt_pkg::W_W-1:0]    out_weight_out_2,
  output logic [swbt_pkg::W_W-1:0]    out_weight_out_3,
  output logic                        out_painted,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);

  import swbt_pkg::*;

  localparam int NL    = (LAYERS < NL_MAX) ? LAYERS : NL_MAX;
  localparam int SUM_W = 17 + $clog2(NL_MAX);
  localparam int TX_W  = $bits(texel_t);
  localparam int WV_W  = NL_MAX * 17;

  // configuration
  logic [14:0] radius_r;
  logic [15:0] gain_r;
  logic [15:0] curve_r;
  logic [1:0]  shape_r;
  logic [2:0]  falloff_r;
  logic [2:0]  blend_r;
  logic [1:0]  target_r;
  logic        norm_r;
  logic [14:0] r_eff;
  logic [29:0] rr_r;

  assign cfg_ready = 1'b1;
  assign r_eff     = (radius_r == 15'd0) ? 15'd1 : radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= 15'd1280;
      gain_r    <= 16'd16384;
      curve_r   <= 16'd32768;
      shape_r   <= 2'd0;
      falloff_r <= FALL_SMOOTH;
      blend_r   <= 3'd0;
      target_r  <= 2'd0;
      norm_r    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS:  radius_r  <= cfg_data[14:0];
        REG_GAIN:    gain_r    <= cfg_data;
        REG_CURVE:   curve_r   <= cfg_data;
        REG_SHAPE:   shape_r   <= cfg_data[1:0];
        REG_FALLOFF: falloff_r <= cfg_data[2:0];
        REG_BLEND:   blend_r   <= cfg_data[2:0];
        REG_TARGET:  target_r  <= cfg_data[1:0];
        REG_NORM:    norm_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rr_r <= r_eff * r_eff;
  end

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1: capture, magnitudes
  logic        s1_v_r;
  logic [15:0] s1_ax_r;
  logic [15:0] s1_az_r;
  texel_t      s1_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax_r   <= in_offset_x[15] ? 16'(16'd0 - in_offset_x) : in_offset_x;
      s1_az_r   <= in_offset_z[15] ? 16'(16'd0 - in_offset_z) : in_offset_z;
      s1_t_r.w  <= {in_weight_in_3, in_weight_in_2, in_weight_in_1, in_weight_in_0};
      s1_t_r.flow <= in_flow;
    end
  end

  // stage 2: squares, shape test
  logic        s2_v_r;
  logic [31:0] s2_sqx_r;
  logic [31:0] s2_sqz_r;
  logic        s2_ok_r;
  texel_t      s2_t_r;
  logic        shape_ok;
  logic [16:0] sum_xz;

  assign sum_xz = {1'b0, s1_ax_r} + {1'b0, s1_az_r};

  always_comb begin
    case (shape_r)
      SHAPE_SQUARE:  shape_ok = (s1_ax_r <= {1'b0, r_eff}) && (s1_az_r <= {1'b0, r_eff});
      SHAPE_DIAMOND: shape_ok = sum_xz <= {2'b00, r_eff};
      default:       shape_ok = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx_r <= s1_ax_r * s1_ax_r;
      s2_sqz_r <= s1_az_r * s1_az_r;
      s2_ok_r  <= shape_ok && ({1'b0, target_r} < 3'(NL));
      s2_t_r   <= s1_t_r;
    end
  end

  // stage 3: distance and radius test
  logic        s3_v_r;
  logic [31:0] s3_dist_r;
  logic        s3_hit_r;
  texel_t      s3_t_r;
  logic [31:0] dist2;

  assign dist2 = s2_sqx_r + s2_sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_dist_r <= dist2;
      s3_hit_r  <= s2_ok_r && (dist2 <= {2'b00, rr_r});
      s3_t_r    <= s2_t_r;
    end
  end

  // distance root
  logic            d_v;
  logic [31:0]     d_root;
  logic [TX_W:0]   d_sb;

  swbt_sqrt #(.IN_W(64), .SB_W(TX_W + 1)) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s3_v_r),
    .in_x     ({s3_dist_r, 32'd0}),
    .in_sb    ({s3_hit_r, s3_t_r}),
    .out_valid(d_v),
    .out_root (d_root),
    .out_sb   (d_sb)
  );

  // stage 4: range check ahead of d/r
  logic          s4_v_r;
  logic [31:0]   s4_root_r;
  logic          s4_sat_r;
  logic [TX_W:0] s4_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_root_r <= d_root;
      s4_sat_r  <= d_root >= {1'b0, r_eff, 16'd0};
      s4_sb_r   <= d_sb;
    end
  end

  logic            q_v;
  logic [0:0][15:0] q_nd;
  logic [TX_W+1:0] q_sb;

  swbt_div #(.LANES(1), .N_W(32), .D_W(15), .Q_W(16), .SB_W(TX_W + 2)) u_ndiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s4_v_r),
    .in_num   (s4_root_r),
    .in_den   (r_eff),
    .in_sb    ({s4_sat_r, s4_sb_r}),
    .out_valid(q_v),
    .out_quo  (q_nd),
    .out_sb   (q_sb)
  );

  // stage 5: falloff base and exponent
  logic             s5_v_r;
  logic [16:0]      s5_base_r;
  logic [EXP_W-1:0] s5_exp_r;
  logic [TX_W:0]    s5_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_base_r <= q_sb[TX_W+1] ? 17'd0 : ONE_Q16 - {1'b0, q_nd[0]};
      s5_exp_r  <= (falloff_r == FALL_SHARP) ?
                   20'h20000 + {1'b0, curve_r, 3'b000} :
                   20'h10000 + {3'b000, curve_r, 1'b0} + {4'b0000, curve_r};
      s5_sb_r   <= q_sb[TX_W:0];
    end
  end

  logic             p_v;
  logic [16:0]      p_pow;
  logic [TX_W+17:0] p_sb;

  swbt_pow #(.SB_W(TX_W + 18)) u_pow (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s5_v_r),
    .in_base  (s5_base_r),
    .in_expo  (s5_exp_r),
    .in_sb    ({s5_base_r, s5_sb_r}),
    .out_valid(p_v),
    .out_pow  (p_pow),
    .out_sb   (p_sb)
  );

  // stage 6: falloff select
  logic        s6_v_r;
  logic [16:0] s6_fw_r;
  texel_t      s6_t_r;
  logic [16:0] fw;

  always_comb begin
    case (falloff_r)
      FALL_SMOOTH, FALL_SHARP: fw = p_pow;
      FALL_CONST:              fw = ONE_Q16;
      default:                 fw = p_sb[TX_W+17 -: 17];
    endcase
    if (!p_sb[TX_W]) begin
      fw = 17'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_fw_r <= fw;
      s6_t_r  <= p_sb[TX_W-1:0];
    end
  end

  // stage 7: brush weight
  logic        s7_v_r;
  logic [16:0] s7_bw_r;
  texel_t      s7_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_bw_r <= qmul(s6_fw_r, s6_t_r.flow);
      s7_t_r  <= s6_t_r;
    end
  end

  // stage 8: paint strength
  logic        s8_v_r;
  logic [16:0] s8_ps_r;
  logic        s8_painted_r;
  texel_t      s8_t_r;
  logic [16:0] ps_raw;

  assign ps_raw = qmul(s7_bw_r, {1'b0, gain_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (en) begin
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_ps_r      <= (ps_raw > ONE_Q16) ? ONE_Q16 : ps_raw;
      s8_painted_r <= s7_bw_r != 17'd0;
      s8_t_r       <= s7_t_r;
    end
  end

  // root of the target weight for soft light
  logic             r_v;
  logic [15:0]      r_sqw;
  logic [TX_W+17:0] r_sb;

  swbt_sqrt #(.IN_W(32), .SB_W(TX_W + 18)) u_soft (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s8_v_r),
    .in_x     ({s8_t_r.w[target_r], 16'd0}),
    .in_sb    ({s8_ps_r, s8_painted_r, s8_t_r}),
    .out_valid(r_v),
    .out_root (r_sqw),
    .out_sb   (r_sb)
  );

  // stage 9: blend products
  logic        s9_v_r;
  logic [33:0] s9_m1_r;
  logic [32:0] s9_m2_r;
  logic        s9_low_r;
  logic [16:0] s9_ps_r;
  logic        s9_painted_r;
  texel_t      s9_t_r;
  texel_t      r_t;
  logic [16:0] r_ps;
  logic [15:0] r_wt;
  logic [16:0] ma;
  logic [16:0] mb;
  logic        low;

  assign r_t  = r_sb[TX_W-1:0];
  assign r_ps = r_sb[TX_W+17 -: 17];
  assign r_wt = r_t.w[target_r];
  assign low  = (blend_r == BL_OVER) ? (r_wt < 16'h8000) : (r_ps < 17'h08000);

  always_comb begin
    case (blend_r)
      BL_OVER, BL_HARD: begin
        ma = low ? {1'b0, r_wt} : ONE_Q16 - {1'b0, r_wt};
        mb = low ? r_ps : ONE_Q16 - r_ps;
      end
      BL_SOFT: begin
        ma = {1'b0, r_wt};
        mb = ONE_Q16 - r_ps;
      end
      default: begin
        ma = ONE_Q16 - {1'b0, r_wt};
        mb = r_ps;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_v_r <= 1'b0;
    end else if (en) begin
      s9_v_r <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_m1_r      <= ma * mb;
      s9_m2_r      <= r_sqw * r_ps;
      s9_low_r     <= low;
      s9_ps_r      <= r_ps;
      s9_painted_r <= r_sb[TX_W];
      s9_t_r       <= r_t;
    end
  end

  // stage 10: blend result, clamp, write back into the target layer
  logic                     s10_v_r;
  logic [NL_MAX-1:0][16:0]  s10_w_r;
  logic                     s10_painted_r;
  logic [15:0]              wt9;
  logic signed [18:0]       nw;
  logic [34:0]              soft_sum;
  logic [16:0]              nw_c;

  assign wt9      = s9_t_r.w[target_r];
  assign soft_sum = {1'b0, s9_m1_r} + {2'b00, s9_m2_r};

  always_comb begin
    case (blend_r)
      BL_ADD:  nw = $signed({3'b000, wt9}) + $signed({2'b00, s9_ps_r});
      BL_SUB:  nw = $signed({3'b000, wt9}) - $signed({2'b00, s9_ps_r});
      BL_MUL:  nw = $signed({3'b000, wt9});
      BL_OVER, BL_HARD:
        nw = s9_low_r ? $signed(s9_m1_r[33:15]) :
             $signed({2'b00, ONE_Q16}) - $signed(s9_m1_r[33:15]);
      BL_SOFT: nw = $signed(soft_sum[34:16]);
      default: nw = $signed({3'b000, wt9}) + $signed({1'b0, s9_m1_r[33:16]});
    endcase
    if (nw < 0) begin
      nw_c = 17'd0;
    end else if (nw > $signed({2'b00, ONE_Q16})) begin
      nw_c = ONE_Q16;
    end else begin
      nw_c = nw[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_v_r <= 1'b0;
    end else if (en) begin
      s10_v_r <= s9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_painted_r <= s9_painted_r;
      for (int i = 0; i < NL_MAX; i++) begin
        s10_w_r[i] <= (s9_painted_r && (target_r == 2'(i))) ? nw_c : {1'b0, s9_t_r.w[i]};
      end
    end
  end

  // stage 11: layer sum
  logic                    s11_v_r;
  logic [SUM_W-1:0]        s11_sum_r;
  logic [NL_MAX-1:0][16:0] s11_w_r;
  logic                    s11_painted_r;
  logic [SUM_W-1:0]        sum;
  logic [NL-1:0][32:0]     nnum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NL; i++) begin
      sum = sum + SUM_W'(s10_w_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s11_v_r <= 1'b0;
    end else if (en) begin
      s11_v_r <= s10_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_sum_r     <= sum;
      s11_w_r       <= s10_w_r;
      s11_painted_r <= s10_painted_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      nnum[i] = {s11_w_r[i], 16'd0};
    end
  end

  logic                n_v;
  logic [NL-1:0][16:0] n_quo;
  logic [WV_W+1:0]     n_sb;
  logic [NL_MAX-1:0][16:0] n_w;

  swbt_div #(.LANES(NL), .N_W(33), .D_W(SUM_W), .Q_W(17), .SB_W(WV_W + 2)) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s11_v_r),
    .in_num   (nnum),
    .in_den   (s11_sum_r),
    .in_sb    ({s11_w_r, s11_painted_r, s11_sum_r == '0}),
    .out_valid(n_v),
    .out_quo  (n_quo),
    .out_sb   (n_sb)
  );

  assign n_w = n_sb[WV_W+1:2];

  // output register
  logic [NL_MAX-1:0][15:0] fin;
  logic [NL_MAX-1:0][15:0] out_w_r;
  logic                    out_painted_r;

  for (genvar g = 0; g < NL_MAX; g++) begin : g_lane
    logic [16:0] val;
    if (g < NL) begin : g_norm
      always_comb begin
        val = n_w[g];
        if (n_sb[1] && norm_r) begin
          if (n_sb[0]) begin
            val = (g == 0) ? ONE_Q16 : n_w[g];
          end else begin
            val = n_quo[g];
          end
        end
      end
    end else begin : g_pass
      assign val = n_w[g];
    end
    assign fin[g] = val[16] ? 16'hFFFF : val[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= n_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w_r       <= fin;
      out_painted_r <= n_sb[1];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_weight_out_0 = out_w_r[0];
  assign out_weight_out_1 = out_w_r[1];
  assign out_weight_out_2 = out_w_r[2];
  assign out_weight_out_3 = out_w_r[3];
  assign out_painted      = out_painted_r;

endmodule
